### hw/rtl/stip_pkg.sv
// stip_pkg: shared types, character codes and helpers of the string to integer parser
// used by stip_step and string_to_integer_parser_unit; no dependencies
`default_nettype none

package stip_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int VALUE_WIDTH  = 64;
  localparam int OFFSET_WIDTH = 16;
  localparam int BASE_WIDTH   = 5;
  localparam int DIGIT_WIDTH  = 5;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = BASE_WIDTH'(0);
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = BASE_WIDTH'(8);
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = BASE_WIDTH'(10);
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = BASE_WIDTH'(16);

  localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = DIGIT_WIDTH'(16);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [OFFSET_WIDTH-1:0]       end_offset;
    logic                          done_res;
  } rsp_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    negative;
    logic [VALUE_WIDTH-1:0]  accum;
    logic [BASE_WIDTH-1:0]   base;
    logic [COUNT_WIDTH-1:0]  consumed;
    logic                    stopped;
  } parse_state_t;

  // hex value of a character, DIGIT_NONE when it is not a hex digit
  function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [7:0] c);
    logic [DIGIT_WIDTH-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_WIDTH'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      d = DIGIT_WIDTH'(c - CH_LA) + DIGIT_WIDTH'(10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = DIGIT_WIDTH'(c - CH_UA) + DIGIT_WIDTH'(10);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/stip_step.sv
// stip_step: next parse state for one character
// depends on stip_pkg
`default_nettype none

module stip_step (
  input  stip_pkg::parse_state_t            cur,
  input  stip_pkg::req_t                    req,
  input  logic [stip_pkg::BASE_WIDTH-1:0]   radix,
  output stip_pkg::parse_state_t            nxt
);

  stip_pkg::parse_state_t            s;
  logic                              lead;
  logic                              take_digit;
  logic                              count;
  logic [stip_pkg::DIGIT_WIDTH-1:0]  d;

  assign d = stip_pkg::digit_of(req.ch);

  always_comb begin
    // a new string restarts from the clean state with the configured base
    s = cur;
    if (req.first) begin
      s.phase    = stip_pkg::PH_SPACE;
      s.negative = 1'b0;
      s.accum    = '0;
      s.base     = radix;
      s.consumed = '0;
      s.stopped  = 1'b0;
    end

    nxt        = s;
    lead       = 1'b0;
    take_digit = 1'b0;
    count      = 1'b0;

    if (!s.stopped) begin
      unique case (s.phase)
        stip_pkg::PH_SPACE: begin
          if (req.ch == stip_pkg::CH_SPACE || req.ch == stip_pkg::CH_TAB ||
              req.ch == stip_pkg::CH_LF) begin
            count = 1'b1;
          end else if (req.ch == stip_pkg::CH_MINUS || req.ch == stip_pkg::CH_PLUS) begin
            nxt.negative = (req.ch == stip_pkg::CH_MINUS);
            nxt.phase    = stip_pkg::PH_SIGNED;
            count        = 1'b1;
          end else begin
            lead = 1'b1;
          end
        end
        stip_pkg::PH_SIGNED: begin
          lead = 1'b1;
        end
        stip_pkg::PH_ZERO: begin
          if (req.ch == stip_pkg::CH_LX || req.ch == stip_pkg::CH_UX) begin
            nxt.base  = stip_pkg::BASE_HEX;
            nxt.phase = stip_pkg::PH_DIGITS;
            count     = 1'b1;
          end else begin
            take_digit = 1'b1;
          end
        end
        default: begin
          take_digit = 1'b1;
        end
      endcase

      if (lead) begin
        if (req.ch == stip_pkg::CH_ZERO &&
            (s.base == stip_pkg::BASE_AUTO || s.base == stip_pkg::BASE_HEX)) begin
          // leading zero: possible 0x prefix, or octal in auto mode
          if (s.base == stip_pkg::BASE_AUTO) begin
            nxt.base = stip_pkg::BASE_OCT;
          end
          nxt.phase = stip_pkg::PH_ZERO;
          count     = 1'b1;
        end else begin
          if (s.base == stip_pkg::BASE_AUTO) begin
            nxt.base = stip_pkg::BASE_DEC;
          end
          take_digit = 1'b1;
        end
      end

      if (take_digit) begin
        if (req.ch == stip_pkg::CH_NUL || d == stip_pkg::DIGIT_NONE ||
            stip_pkg::BASE_WIDTH'(d) >= nxt.base) begin
          nxt.stopped = 1'b1;
        end else begin
          nxt.accum = stip_pkg::VALUE_WIDTH'(s.accum * stip_pkg::VALUE_WIDTH'(nxt.base))
                    + stip_pkg::VALUE_WIDTH'(d);
          nxt.phase = stip_pkg::PH_DIGITS;
          count     = 1'b1;
        end
      end
    end

    if (count && s.consumed != stip_pkg::COUNT_MAX) begin
      nxt.consumed = s.consumed + stip_pkg::COUNT_WIDTH'(1);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/string_to_integer_parser_unit.sv
// string_to_integer_parser_unit: streaming strtol-style integer parser, top level
// depends on stip_pkg and stip_step
//
// One character enters per request; every request returns exactly one response with the
// signed value parsed so far, the count of characters consumed and a done flag. The
// unit sustains one character per clock while rsp_ready is high: the request is held
// in an input register, the next parse state (a 64-bit multiply by the active base plus
// the digit, and the sign applied) is formed from it and lands in the response register,
// so each response passes the input register and then the response register before it
// is offered, and a full response register stalls the input register. The loop that
// sets this rate is the accumulator update, formed combinationally. Leading space, tab and
// newline are skipped, then one '+' or '-', then a 0x/0X prefix (radix 0 or 16) or an
// octal leading zero (radix 0); digits below the active base are accumulated modulo
// 2^64. The first non-digit or NUL stops the parse, and later characters only repeat the
// last result with done_res set until a request with first set starts a new string.
// When no digit follows, end_offset still counts whitespace, sign and prefix. radix is
// latched on each first character; write it only while no request is in flight.
`default_nettype none

module string_to_integer_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [stip_pkg::BASE_WIDTH-1:0]     cfg_wdata,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  stip_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output stip_pkg::rsp_t                      rsp
);

  // configuration register
  logic [stip_pkg::BASE_WIDTH-1:0] radix;

  // input register
  logic           hold_valid;
  stip_pkg::req_t hold;

  // parse state carried between characters
  stip_pkg::parse_state_t state;
  stip_pkg::parse_state_t state_next;

  // the held request moves on when the response register is free or being drained
  logic advance;

  assign advance   = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= stip_pkg::BASE_DEC;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      hold <= req;
    end
  end

  // one parse step per character
  stip_step u_step (
    .cur   (state),
    .req   (hold),
    .radix (radix),
    .nxt   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase    <= stip_pkg::PH_SPACE;
      state.negative <= 1'b0;
      state.accum    <= '0;
      state.base     <= stip_pkg::BASE_DEC;
      state.consumed <= '0;
      state.stopped  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // response register: sign applied on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.value      <= state_next.negative ? -$signed(state_next.accum)
                                            : $signed(state_next.accum);
      rsp.end_offset <= stip_pkg::OFFSET_WIDTH'(state_next.consumed);
      rsp.done_res   <= state_next.stopped;
    end
  end

endmodule

`default_nettype wire
